// ----- design/utf8sd_pkg.sv -----
`default_nettype none

package utf8sd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned CpWidth     = 31;
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned PendWidth   = 3;
   localparam int unsigned CsrIdxWidth = 2;
   localparam int unsigned CsrWidth    = 16;

   // Lead byte classification: mask and match per sequence length
   localparam logic [ByteWidth-1:0] AsciiMask  = 8'h80;
   localparam logic [ByteWidth-1:0] Lead2Mask  = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead2Match = 8'hC0;
   localparam logic [ByteWidth-1:0] Lead3Mask  = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead3Match = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead4Mask  = 8'hF8;
   localparam logic [ByteWidth-1:0] Lead4Match = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead5Mask  = 8'hFC;
   localparam logic [ByteWidth-1:0] Lead5Match = 8'hF8;
   localparam logic [ByteWidth-1:0] Lead6Mask  = 8'hFE;
   localparam logic [ByteWidth-1:0] Lead6Match = 8'hFC;

   localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
   localparam logic [PendWidth-1:0]  PendMax  = 3'd5;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TRUNCATE_SIXTEEN = 2'd0,
      CSR_LIMIT_ENABLE     = 2'd1,
      CSR_CHAR_LIMIT       = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

// ----- design/utf8_stream_decoder.sv -----
`default_nettype none
// An accepted beat's code point goes straight into the result register behind rsp_.
// Throughput: one byte per cycle while the result slot is free or draining; the state
// update and the result register sit behind a single pass of decode logic, and the result
// register is refilled while being drained. Reset (synchronous, active high): clears decode
// state, registers and rsp_valid; req_ready is held low while reset is high.

module utf8_stream_decoder (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [utf8sd_pkg::ByteWidth-1:0]     req_data_byte,
   input  wire logic                                 req_string_start,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [utf8sd_pkg::CpWidth-1:0]            rsp_code_point,
   input  wire logic                                 csr_write_enable,
   input  wire logic [utf8sd_pkg::CsrIdxWidth-1:0]   csr_index,
   input  wire logic [utf8sd_pkg::CsrWidth-1:0]      csr_write_data
);

   // Configuration registers
   logic                                  truncate_ff;
   logic                                  limit_enable_ff;
   logic [utf8sd_pkg::CountWidth-1:0]     char_limit_ff;

   // Decode state
   logic [utf8sd_pkg::PendWidth-1:0]      pending_ff,  pending_in;
   logic [utf8sd_pkg::CpWidth-1:0]        partial_ff,  partial_in;
   logic [utf8sd_pkg::CountWidth-1:0]     emitted_ff,  emitted_in;
   logic                                  ended_ff,    ended_in;

   // Result register
   logic                                  rsp_valid_ff;
   logic [utf8sd_pkg::CpWidth-1:0]        rsp_cp_ff,   rsp_cp_in;

   // State as seen by this beat, after the start flag has cleared it
   logic [utf8sd_pkg::PendWidth-1:0]      pend_eff;
   logic [utf8sd_pkg::CpWidth-1:0]        part_eff;
   logic [utf8sd_pkg::CountWidth-1:0]     cnt_eff;
   logic                                  ended_eff;

   logic                                  emit;
   logic [utf8sd_pkg::CpWidth-1:0]        emit_value;
   logic                                  accept;
   logic [utf8sd_pkg::ByteWidth-1:0]      b;

   // Take a new beat whenever the result slot is empty or is being drained
   assign req_ready = !reset && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign b         = req_data_byte;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_cp_ff;

   always_comb begin
      pend_eff  = req_string_start ? '0 : pending_ff;
      part_eff  = req_string_start ? '0 : partial_ff;
      cnt_eff   = req_string_start ? '0 : emitted_ff;
      ended_eff = req_string_start ? 1'b0 : ended_ff;

      pending_in = pend_eff;
      partial_in = part_eff;
      ended_in   = ended_eff;
      emit       = 1'b0;
      emit_value = '0;

      if (!ended_eff) begin
         if (pend_eff != '0) begin
            // Continuation: shift in the low six bits, no check on the marker bits
            partial_in = {part_eff[utf8sd_pkg::CpWidth-7:0], b[5:0]};
            pending_in = pend_eff - 3'd1;
            if (pend_eff == 3'd1) begin
               emit       = 1'b1;
               emit_value = partial_in;
            end
         end else if (b == '0) begin
            // NUL lead closes the string
            ended_in = 1'b1;
         end else if (limit_enable_ff && (cnt_eff >= char_limit_ff)) begin
            ended_in = 1'b1;
         end else if ((b & utf8sd_pkg::AsciiMask) == '0) begin
            emit       = 1'b1;
            emit_value = {{(utf8sd_pkg::CpWidth-utf8sd_pkg::ByteWidth){1'b0}}, b};
         end else if ((b & utf8sd_pkg::Lead2Mask) == utf8sd_pkg::Lead2Match) begin
            partial_in = {{(utf8sd_pkg::CpWidth-5){1'b0}}, b[4:0]};
            pending_in = 3'd1;
         end else if ((b & utf8sd_pkg::Lead3Mask) == utf8sd_pkg::Lead3Match) begin
            partial_in = {{(utf8sd_pkg::CpWidth-4){1'b0}}, b[3:0]};
            pending_in = 3'd2;
         end else if ((b & utf8sd_pkg::Lead4Mask) == utf8sd_pkg::Lead4Match) begin
            partial_in = {{(utf8sd_pkg::CpWidth-3){1'b0}}, b[2:0]};
            pending_in = 3'd3;
         end else if ((b & utf8sd_pkg::Lead5Mask) == utf8sd_pkg::Lead5Match) begin
            partial_in = {{(utf8sd_pkg::CpWidth-2){1'b0}}, b[1:0]};
            pending_in = 3'd4;
         end else if ((b & utf8sd_pkg::Lead6Mask) == utf8sd_pkg::Lead6Match) begin
            partial_in = {{(utf8sd_pkg::CpWidth-1){1'b0}}, b[0]};
            pending_in = 3'd5;
         end else begin
            // Stray continuation or 0xFE/0xFF: pass the byte through as is
            emit       = 1'b1;
            emit_value = {{(utf8sd_pkg::CpWidth-utf8sd_pkg::ByteWidth){1'b0}}, b};
         end
      end

      // Truncate mode keeps the low sixteen bits only
      rsp_cp_in = truncate_ff ? {15'd0, emit_value[15:0]} : emit_value;

      // Count emitted characters, saturating
      emitted_in = cnt_eff;
      if (emit && (cnt_eff != utf8sd_pkg::CountMax)) begin
         emitted_in = cnt_eff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         truncate_ff     <= 1'b0;
         limit_enable_ff <= 1'b0;
         char_limit_ff   <= '0;
         pending_ff      <= '0;
         partial_ff      <= '0;
         emitted_ff      <= '0;
         ended_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               utf8sd_pkg::CSR_TRUNCATE_SIXTEEN: truncate_ff     <= csr_write_data[0];
               utf8sd_pkg::CSR_LIMIT_ENABLE:     limit_enable_ff <= csr_write_data[0];
               utf8sd_pkg::CSR_CHAR_LIMIT:       char_limit_ff   <= csr_write_data;
               default: ; // drop writes beyond the register list
            endcase
         end

         // Drain the result slot, then refill it from an accepted beat
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            pending_ff   <= pending_in;
            partial_ff   <= partial_in;
            emitted_ff   <= emitted_in;
            ended_ff     <= ended_in;
            if (emit) begin
               rsp_valid_ff <= 1'b1;
            end
         end
      end
   end

   // Payload register, no reset
   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_cp_ff <= rsp_cp_in;
      end
   end

   // Legacy six-byte form is the longest sequence
   a_pending_range: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= utf8sd_pkg::PendMax)
      else $error("bytes pending beyond longest sequence");

   // An ended string emits nothing until the next start flag
   a_ended_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && ended_ff && !req_string_start) |=> !rsp_valid_ff)
      else $error("result emitted after end of string");

   // Character count only grows within a string
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_string_start) |=> (emitted_ff >= $past(emitted_ff)))
      else $error("character count went backwards");

   // A result carries the continuation count down to zero
   a_emit_closes_seq: assert property (@(posedge clock) disable iff (reset)
      (accept && emit) |=> (pending_ff == '0))
      else $error("result emitted with continuation bytes outstanding");

endmodule

`default_nettype wire

// ----- sim/utf8_stream_decoder_test.sv -----
`timescale 1ns / 1ps

module utf8_stream_decoder_test;

   // Cycle budget: about 1200 beats, each at worst a long sender gap plus a long
   // receiver stall, with drains between phases. Taken several times over.
   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned CpPad      = utf8sd_pkg::CpWidth - utf8sd_pkg::ByteWidth;

   typedef struct {
      logic [utf8sd_pkg::ByteWidth-1:0] data;
      logic                             start;
   } byte_beat_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;

   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic [utf8sd_pkg::ByteWidth-1:0]      req_data_byte = '0;
   logic                                  req_string_start = 1'b0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic [utf8sd_pkg::CpWidth-1:0]        rsp_code_point;
   logic                                  csr_write_enable = 1'b0;
   utf8sd_pkg::csr_index_type             csr_index = utf8sd_pkg::CSR_TRUNCATE_SIXTEEN;
   logic [utf8sd_pkg::CsrWidth-1:0]       csr_write_data = '0;

   // Bytes waiting for the driver, and code points waiting for the monitor
   byte_beat_type                         pending_bytes[$];
   logic [utf8sd_pkg::CpWidth-1:0]        expected_cps[$];

   // Mirror of the configuration registers
   bit                                    trunc_mode  = 1'b0;
   bit                                    limit_on    = 1'b0;
   logic [utf8sd_pkg::CountWidth-1:0]     limit_chars = '0;

   // Mirror of the decode state
   logic [utf8sd_pkg::PendWidth-1:0]      seq_left  = '0;
   logic [utf8sd_pkg::CpWidth-1:0]        seq_acc   = '0;
   logic [utf8sd_pkg::CountWidth-1:0]     str_chars = '0;
   bit                                    str_done  = 1'b0;

   int unsigned            fail_count = 0;
   int unsigned            cycle_count = 0;
   int unsigned            phase_beats = 0;
   int unsigned            tx_gap = 0;
   int unsigned            tx_calm = 0;
   int unsigned            rx_stall = 0;
   int unsigned            rx_calm = 0;

   utf8_stream_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_string_start (req_string_start),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_code_point   (rsp_code_point),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // Idle length: mostly none or short, a few long, and now and then a calm
   // stretch with no idling at all.
   function automatic int unsigned idle_len(inout int unsigned calm_left);
      int unsigned r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Advance the decode state by one byte; return 1 when a code point is due.
   function automatic bit decode_byte(input logic [utf8sd_pkg::ByteWidth-1:0] b,
                                      input logic start,
                                      output logic [utf8sd_pkg::CpWidth-1:0] cp);
      logic [utf8sd_pkg::CpWidth-1:0] v;
      bit                             emit;
      emit = 1'b0;
      v    = '0;
      // a start flag drops any half-received sequence and reopens the string
      if (start) begin
         seq_left  = '0;
         seq_acc   = '0;
         str_chars = '0;
         str_done  = 1'b0;
      end
      if (str_done) begin
         emit = 1'b0;
      end else if (seq_left != 0) begin
         // continuation: low six bits, no check of the top two
         seq_acc  = {seq_acc[utf8sd_pkg::CpWidth-7:0], b[5:0]};
         seq_left = seq_left - 1'b1;
         if (seq_left == 0) begin
            emit = 1'b1;
            v    = seq_acc;
         end
      end else if (b == 8'h00) begin
         str_done = 1'b1;
      end else if (limit_on && str_chars >= limit_chars) begin
         str_done = 1'b1;
      end else if ((b & utf8sd_pkg::AsciiMask) == 8'h00) begin
         emit = 1'b1;
         v    = {{CpPad{1'b0}}, b};
      end else if ((b & utf8sd_pkg::Lead2Mask) == utf8sd_pkg::Lead2Match) begin
         seq_acc  = {{(utf8sd_pkg::CpWidth-5){1'b0}}, b[4:0]};
         seq_left = 3'd1;
      end else if ((b & utf8sd_pkg::Lead3Mask) == utf8sd_pkg::Lead3Match) begin
         seq_acc  = {{(utf8sd_pkg::CpWidth-4){1'b0}}, b[3:0]};
         seq_left = 3'd2;
      end else if ((b & utf8sd_pkg::Lead4Mask) == utf8sd_pkg::Lead4Match) begin
         seq_acc  = {{(utf8sd_pkg::CpWidth-3){1'b0}}, b[2:0]};
         seq_left = 3'd3;
      end else if ((b & utf8sd_pkg::Lead5Mask) == utf8sd_pkg::Lead5Match) begin
         seq_acc  = {{(utf8sd_pkg::CpWidth-2){1'b0}}, b[1:0]};
         seq_left = 3'd4;
      end else if ((b & utf8sd_pkg::Lead6Mask) == utf8sd_pkg::Lead6Match) begin
         seq_acc  = {{(utf8sd_pkg::CpWidth-1){1'b0}}, b[0]};
         seq_left = utf8sd_pkg::PendMax;
      end else begin
         // stray continuation or 0xFE/0xFF as a lead: pass the byte through
         emit = 1'b1;
         v    = {{CpPad{1'b0}}, b};
      end
      if (emit) begin
         if (trunc_mode) v[utf8sd_pkg::CpWidth-1:16] = '0;
         if (str_chars != utf8sd_pkg::CountMax) str_chars = str_chars + 1'b1;
      end
      cp = v;
      return emit;
   endfunction

   // Driver: hold each beat until accepted, then idle for a random gap.
   always @(posedge clock) begin : drive_bytes
      int unsigned   g;
      byte_beat_type nb;
      if (reset) begin
         req_valid <= 1'b0;
         tx_gap    <= 0;
      end else if (!req_valid || req_ready) begin
         g = tx_gap;
         if (req_valid) g = idle_len(tx_calm);
         if (g > 0) begin
            req_valid <= 1'b0;
            tx_gap    <= g - 1;
         end else if (pending_bytes.size() > 0) begin
            nb = pending_bytes.pop_front();
            req_valid        <= 1'b1;
            req_data_byte    <= nb.data;
            req_string_start <= nb.start;
            tx_gap           <= 0;
         end else begin
            req_valid <= 1'b0;
            tx_gap    <= 0;
         end
      end
   end

   // Predict on every accepted byte
   always @(posedge clock) begin : predict_bytes
      logic [utf8sd_pkg::CpWidth-1:0] cp;
      if (!reset && req_valid && req_ready) begin
         if (decode_byte(req_data_byte, req_string_start, cp)) begin
            expected_cps.insert(expected_cps.size(), cp);
         end
      end
   end

   // Receiver: stall at random, check every accepted code point against the oldest
   always @(posedge clock) begin : check_code_points
      int unsigned                    s;
      logic [utf8sd_pkg::CpWidth-1:0] want;
      if (rx_stall > 0) begin
         rx_stall  <= rx_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         s = ($urandom_range(0, 2) == 0) ? idle_len(rx_calm) : 0;
         rsp_ready <= (s == 0);
         rx_stall  <= (s > 0) ? s - 1 : 0;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_cps.size() == 0) begin
            $display("%0t: unexpected code point, expected none, actual %h",
                     $time, rsp_code_point);
            fail_count++;
         end else begin
            want = expected_cps.pop_front();
            if (rsp_code_point !== want) begin
               $display("%0t: code point mismatch, expected %h, actual %h",
                        $time, want, rsp_code_point);
               fail_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic push_byte(input logic [utf8sd_pkg::ByteWidth-1:0] data, input logic start,
                            input bit counted);
      byte_beat_type nb;
      nb.data  = data;
      nb.start = start;
      pending_bytes.insert(pending_bytes.size(), nb);
      if (counted) phase_beats++;
   endtask

   // Wait until the driver is empty and every code point is back, then let
   // the block's result register settle.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_cps.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(input utf8sd_pkg::csr_index_type idx,
                            input logic [utf8sd_pkg::CsrWidth-1:0] val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      case (idx)
         utf8sd_pkg::CSR_TRUNCATE_SIXTEEN: trunc_mode  = val[0];
         utf8sd_pkg::CSR_LIMIT_ENABLE:     limit_on    = val[0];
         utf8sd_pkg::CSR_CHAR_LIMIT:       limit_chars = val;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input bit trunc, input bit lim_en,
                                 input logic [utf8sd_pkg::CsrWidth-1:0] lim);
      wait_drained();
      write_csr(utf8sd_pkg::CSR_TRUNCATE_SIXTEEN, {15'd0, trunc});
      write_csr(utf8sd_pkg::CSR_LIMIT_ENABLE, {15'd0, lim_en});
      write_csr(utf8sd_pkg::CSR_CHAR_LIMIT, lim);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One string: a start flag on the first byte, then mostly well-formed
   // characters with random payload, salted with stray leads, garbage
   // continuations and sequences cut short. Sometimes close it with a NUL
   // and trail up to three bytes that the block drops unless the NUL lands mid-sequence.
   task automatic queue_string(input int unsigned n_chars);
      int unsigned                      k, j, len, r;
      logic [utf8sd_pkg::ByteWidth-1:0] lead, b;
      bit                               first;
      first = 1'b1;
      for (k = 0; k < n_chars; k++) begin
         r = $urandom_range(0, 99);
         if (r < 35)      len = 1;
         else if (r < 55) len = 2;
         else if (r < 70) len = 3;
         else if (r < 82) len = 4;
         else if (r < 90) len = 5;
         else             len = 6;
         case (len)
            1:       lead = 8'($urandom_range(1, 127));
            2:       lead = utf8sd_pkg::Lead2Match | 8'($urandom & 8'h1F);
            3:       lead = utf8sd_pkg::Lead3Match | 8'($urandom & 8'h0F);
            4:       lead = utf8sd_pkg::Lead4Match | 8'($urandom & 8'h07);
            5:       lead = utf8sd_pkg::Lead5Match | 8'($urandom & 8'h03);
            default: lead = utf8sd_pkg::Lead6Match | 8'($urandom & 8'h01);
         endcase
         r = $urandom_range(0, 99);
         if (r < 4) begin
            lead = (r < 2) ? (8'h80 | 8'($urandom & 8'h3F)) : (8'hFE | 8'($urandom & 8'h01));
            len  = 1;
         end
         push_byte(lead, first, 1'b1);
         first = 1'b0;
         for (j = 1; j < len; j++) begin
            // cut the sequence short now and then; the next byte lands mid-sequence
            if ($urandom_range(0, 29) == 0) break;
            if ($urandom_range(0, 19) == 0) b = 8'($urandom);
            else                            b = 8'h80 | 8'($urandom & 8'h3F);
            push_byte(b, 1'b0, 1'b1);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         push_byte(8'h00, 1'b0, 1'b1);
         repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0, 1'b0);
      end
   endtask

   task automatic run_phase(input bit trunc, input bit lim_en,
                            input logic [utf8sd_pkg::CsrWidth-1:0] lim,
                            input int unsigned budget, input bit drain_midway);
      int unsigned top;
      bit          drained;
      apply_settings(trunc, lim_en, lim);
      phase_beats = 0;
      drained     = 1'b0;
      while (phase_beats < budget) begin
         // with a limit, keep strings near it so most bytes still decode
         top = 24;
         if (lim_en && lim + 3 < top) top = lim + 3;
         queue_string($urandom_range(1, top));
         if (drain_midway && !drained && phase_beats >= budget / 2) begin
            // hold the sender until every code point is back
            wait_drained();
            drained = 1'b1;
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset settings. A byte before any start flag decodes.
      push_byte(8'h41, 1'b0, 1'b0);
      // highest ASCII opening a string
      push_byte(8'h7F, 1'b1, 1'b0);
      // six-byte form, all ones: top of the range
      push_byte(8'hFD, 1'b0, 1'b0);
      repeat (5) push_byte(8'hBF, 1'b0, 1'b0);
      // four- and five-byte forms
      push_byte(8'hF4, 1'b0, 1'b0);
      push_byte(8'h8F, 1'b0, 1'b0);
      push_byte(8'hBF, 1'b0, 1'b0);
      push_byte(8'hBF, 1'b0, 1'b0);
      push_byte(8'hF8, 1'b0, 1'b0);
      push_byte(8'h88, 1'b0, 1'b0);
      repeat (3) push_byte(8'h80, 1'b0, 1'b0);
      // leads that start nothing pass straight through
      push_byte(8'h80, 1'b0, 1'b0);
      push_byte(8'hFE, 1'b0, 1'b0);
      push_byte(8'hFF, 1'b0, 1'b0);
      // NUL as a continuation is consumed, not an end of string
      push_byte(8'hC2, 1'b0, 1'b0);
      push_byte(8'h00, 1'b0, 1'b0);
      // start flag in the middle of a sequence drops the partial value
      push_byte(8'hE2, 1'b0, 1'b0);
      push_byte(8'h41, 1'b1, 1'b0);
      // NUL lead ends the string; the next byte is dropped
      push_byte(8'h00, 1'b0, 1'b0);
      push_byte(8'h41, 1'b0, 1'b0);

      // Random phases over the register settings, extremes included
      run_phase(1'b0, 1'b0, 16'd0,     160, 1'b1);
      run_phase(1'b1, 1'b0, 16'd0,     160, 1'b0);
      run_phase(1'b0, 1'b1, 16'd0,      20, 1'b0);
      run_phase(1'b0, 1'b1, 16'd1,     160, 1'b0);
      run_phase(1'b1, 1'b1, 16'hFFFF,  160, 1'b0);
      run_phase(1'b0, 1'b1, 16'($urandom_range(2, 8)), 160, 1'b0);
      run_phase(1'b1, 1'b1, 16'($urandom_range(1, 8)), 160, 1'b0);
      run_phase(1'b0, 1'b0, 16'hFFFF,  160, 1'b0);

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_cps.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
